/* rtl/core/pli_pkg.sv */
`default_nettype none
// -----------------------------------------------------------------------------
// pli_pkg
// Shared types, codes and widths for the positional list unit.
// -----------------------------------------------------------------------------
package pli_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int MODE_W       = 3;
	localparam int VALUE_W      = 32;
	localparam int POS_W        = 8;
	localparam int STATUS_W     = 2;
	localparam int COUNT_W      = 5;

	typedef enum logic [MODE_W-1:0] {
		MODE_INS_FRONT = 3'd0,
		MODE_INS_BACK  = 3'd1,
		MODE_INS_POS   = 3'd2,
		MODE_DEL_FRONT = 3'd3,
		MODE_DEL_BACK  = 3'd4,
		MODE_DEL_POS   = 3'd5,
		MODE_DISPLAY   = 3'd6
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK     = 2'd0,
		ST_BADPOS = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

	// controller to datapath commands
	typedef struct packed {
		logic    mem_we;
		logic    wsel_rd;
		logic    mem_re;
		logic    cnt_inc;
		logic    cnt_dec;
		logic    out_load;
		status_t out_status;
		logic    out_elem_rd;
		logic    out_last;
	} pli_cmd_t;

endpackage
`default_nettype wire

/* rtl/core/pli_if.sv */
`default_nettype none
// -----------------------------------------------------------------------------
// pli_if
// Command and response channel interfaces of the positional list unit.
// -----------------------------------------------------------------------------
interface pli_cmd_if import pli_pkg::*; ;
	logic                      valid;
	logic                      ready;
	logic [MODE_W-1:0]         mode;
	logic signed [VALUE_W-1:0] value;
	logic [POS_W-1:0]          position;

	modport source (output valid, mode, value, position, input ready);
	modport sink (input valid, mode, value, position, output ready);
endinterface

interface pli_rsp_if import pli_pkg::*; ;
	logic                      valid;
	logic                      ready;
	logic [STATUS_W-1:0]       status;
	logic signed [VALUE_W-1:0] element;
	logic                      is_last;
	logic [COUNT_W-1:0]        count;

	modport source (output valid, status, element, is_last, count, input ready);
	modport sink (input valid, status, element, is_last, count, output ready);
endinterface
`default_nettype wire

/* rtl/core/positional_list_insert_delete_unit.sv */
`default_nettype none
// -----------------------------------------------------------------------------
// positional_list_insert_delete_unit
// Bounded ordered list of signed words with positional insert, delete, display.
// -----------------------------------------------------------------------------
// Shifts: one word per cycle, set by one memory read and one write per cycle;
//   m words (m at most count) go through S_PRIME and S_MOVE, inserts then S_PUT.
// Errors go straight to S_RESP, where the response word loads.
// Display: the first word is read, then loaded; then one word per cycle while the
//   receiver keeps taking words.
// Throughput: one command at a time; next command taken the cycle after the last
//   word loads.
// Reset: count and handshake state clear; element memory stays unset until written.
module positional_list_insert_delete_unit import pli_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input wire logic   clk,
	input wire logic   arst_n,
	pli_cmd_if.sink    cmd_ch,
	pli_rsp_if.source  rsp_ch
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = $clog2(CAPACITY);

	pli_cmd_t      cmd;
	logic          in_ld;
	logic          out_free;
	logic [CW-1:0] cnt;
	logic [AW-1:0] waddr;
	logic [AW-1:0] raddr;

	pli_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_ch.valid),
		.cmd_ready (cmd_ch.ready),
		.mode      (cmd_ch.mode),
		.position  (cmd_ch.position),
		.out_free  (out_free),
		.cnt       (cnt),
		.in_ld     (in_ld),
		.cmd       (cmd),
		.waddr     (waddr),
		.raddr     (raddr)
	);

	pli_dp #(.CAPACITY(CAPACITY)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ld    (in_ld),
		.value    (cmd_ch.value),
		.cmd      (cmd),
		.waddr    (waddr),
		.raddr    (raddr),
		.cnt      (cnt),
		.out_free (out_free),
		.valid    (rsp_ch.valid),
		.ready    (rsp_ch.ready),
		.status   (rsp_ch.status),
		.element  (rsp_ch.element),
		.is_last  (rsp_ch.is_last),
		.count    (rsp_ch.count)
	);

endmodule
`default_nettype wire

/* rtl/core/pli_dp.sv */
`default_nettype none
// -----------------------------------------------------------------------------
// pli_dp
// Datapath: element memory, read register, element count and response register.
// -----------------------------------------------------------------------------
module pli_dp import pli_pkg::*; #(
	parameter  int CAPACITY = CAPACITY_DEF,
	localparam int CW       = $clog2(CAPACITY + 1),
	localparam int AW       = $clog2(CAPACITY)
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_ld,
	input  wire logic signed [VALUE_W-1:0] value,
	input  wire pli_cmd_t                  cmd,
	input  wire logic [AW-1:0]             waddr,
	input  wire logic [AW-1:0]             raddr,
	output logic [CW-1:0]                  cnt,
	output logic                           out_free,
	output logic                           valid,
	input  wire logic                      ready,
	output logic [STATUS_W-1:0]            status,
	output logic signed [VALUE_W-1:0]      element,
	output logic                           is_last,
	output logic [COUNT_W-1:0]             count
);

	logic [VALUE_W-1:0]  mem [CAPACITY];
	logic [VALUE_W-1:0]  rd_q;
	logic [VALUE_W-1:0]  value_q;
	logic [CW-1:0]       cnt_q;
	logic                ov_q;
	logic [STATUS_W-1:0] status_q;
	logic [VALUE_W-1:0]  element_q;
	logic                last_q;
	logic [COUNT_W-1:0]  count_q;

	always_ff @(posedge clk) begin
		if (cmd.mem_we) begin
			mem[waddr] <= cmd.wsel_rd ? rd_q : value_q;
		end
		if (cmd.mem_re) begin
			rd_q <= mem[raddr];
		end
		if (in_ld) begin
			value_q <= value;
		end
		if (cmd.out_load) begin
			status_q  <= cmd.out_status;
			element_q <= cmd.out_elem_rd ? rd_q : '0;
			last_q    <= cmd.out_last;
			count_q   <= COUNT_W'(cnt_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ov_q  <= 1'b0;
		end else begin
			if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (cmd.cnt_dec) begin
				cnt_q <= cnt_q - CW'(1);
			end
			if (cmd.out_load) begin
				ov_q <= 1'b1;
			end else if (ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	assign cnt      = cnt_q;
	assign out_free = !ov_q || ready;
	assign valid    = ov_q;
	assign status   = status_q;
	assign element  = $signed(element_q);
	assign is_last  = last_q;
	assign count    = count_q;

endmodule
`default_nettype wire

/* rtl/core/pli_ctrl.sv */
`default_nettype none
// -----------------------------------------------------------------------------
// pli_ctrl
// Controller: decodes a command, sequences the shift moves and the display reads.
// -----------------------------------------------------------------------------
module pli_ctrl import pli_pkg::*; #(
	parameter  int CAPACITY = CAPACITY_DEF,
	localparam int CW       = $clog2(CAPACITY + 1),
	localparam int AW       = $clog2(CAPACITY)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cmd_valid,
	output logic                   cmd_ready,
	input  wire logic [MODE_W-1:0] mode,
	input  wire logic [POS_W-1:0]  position,
	input  wire logic              out_free,
	input  wire logic [CW-1:0]     cnt,
	output logic                   in_ld,
	output pli_cmd_t               cmd,
	output logic [AW-1:0]          waddr,
	output logic [AW-1:0]          raddr
);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_PRIME = 6'b000010,
		S_MOVE  = 6'b000100,
		S_PUT   = 6'b001000,
		S_RESP  = 6'b010000,
		S_DISP  = 6'b100000
	} state_t;

	state_t          state_q, state_d;
	logic [AW-1:0]   src_q, src_d, dst_q, dst_d;
	logic [CW-1:0]   left_q, left_d, olft_q, olft_d;
	logic            up_q, up_d, ins_q, ins_d, pend_q, pend_d;
	status_t         st_q, st_d;

	// decode results
	state_t          dc_next;
	status_t         dc_st;
	logic [AW-1:0]   dc_src, dc_dst;
	logic [CW-1:0]   dc_left, dc_idx;
	logic            dc_up, dc_ins, dc_inc, dc_dec;

	logic            accept, full, empty, pos_ins_ok, pos_del_ok;
	logic [8:0]      c9, pos9;
	logic [CW-1:0]   pos_idx;
	mode_t           m;

	assign cmd_ready  = (state_q == S_IDLE);
	assign accept     = cmd_valid && cmd_ready;
	assign c9         = 9'(cnt);
	assign pos9       = 9'(position);
	assign full       = (cnt == CW'(CAPACITY));
	assign empty      = (cnt == '0);
	assign pos_ins_ok = (position != '0) && (pos9 <= c9 + 9'd1);
	assign pos_del_ok = (position != '0) && (pos9 <= c9);
	assign pos_idx    = CW'(pos9 - 9'd1);
	assign m          = mode_t'(mode);

	always_comb begin
		dc_next = S_IDLE;
		dc_st   = ST_OK;
		dc_src  = '0;
		dc_dst  = '0;
		dc_left = '0;
		dc_idx  = '0;
		dc_up   = 1'b0;
		dc_ins  = 1'b0;
		dc_inc  = 1'b0;
		dc_dec  = 1'b0;
		case (m)
			MODE_INS_FRONT, MODE_INS_BACK, MODE_INS_POS: begin
				if (full) begin
					dc_st   = ST_FULL;
					dc_next = S_RESP;
				end else if (m == MODE_INS_POS && !pos_ins_ok) begin
					dc_st   = ST_BADPOS;
					dc_next = S_RESP;
				end else begin
					if (m == MODE_INS_FRONT) begin
						dc_idx = '0;
					end else if (m == MODE_INS_BACK) begin
						dc_idx = cnt;
					end else begin
						dc_idx = pos_idx;
					end
					// shift the tail up one slot, back to front
					dc_left = cnt - dc_idx;
					dc_dst  = AW'(cnt);
					dc_src  = AW'(cnt - CW'(1));
					dc_ins  = 1'b1;
					dc_inc  = 1'b1;
					dc_next = (dc_left != '0) ? S_PRIME : S_PUT;
				end
			end
			MODE_DEL_FRONT, MODE_DEL_BACK, MODE_DEL_POS: begin
				if (empty) begin
					dc_st   = ST_EMPTY;
					dc_next = S_RESP;
				end else if (m == MODE_DEL_POS && !pos_del_ok) begin
					dc_st   = ST_BADPOS;
					dc_next = S_RESP;
				end else begin
					if (m == MODE_DEL_FRONT) begin
						dc_idx = '0;
					end else if (m == MODE_DEL_BACK) begin
						dc_idx = cnt - CW'(1);
					end else begin
						dc_idx = pos_idx;
					end
					// close the gap, front to back
					dc_left = cnt - CW'(1) - dc_idx;
					dc_src  = AW'(dc_idx + CW'(1));
					dc_dst  = AW'(dc_idx);
					dc_up   = 1'b1;
					dc_dec  = 1'b1;
					dc_next = (dc_left != '0) ? S_PRIME : S_RESP;
				end
			end
			MODE_DISPLAY: begin
				if (empty) begin
					dc_st   = ST_EMPTY;
					dc_next = S_RESP;
				end else begin
					dc_left = cnt;
					dc_next = S_DISP;
				end
			end
			default: begin
				dc_next = S_IDLE;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		src_d   = src_q;
		dst_d   = dst_q;
		left_d  = left_q;
		olft_d  = olft_q;
		up_d    = up_q;
		ins_d   = ins_q;
		pend_d  = pend_q;
		st_d    = st_q;
		cmd     = '0;
		in_ld   = 1'b0;
		waddr   = dst_q;
		raddr   = src_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					in_ld       = 1'b1;
					cmd.cnt_inc = dc_inc;
					cmd.cnt_dec = dc_dec;
					state_d     = dc_next;
					src_d       = dc_src;
					dst_d       = dc_dst;
					left_d      = dc_left;
					olft_d      = dc_left;
					up_d        = dc_up;
					ins_d       = dc_ins;
					st_d        = dc_st;
					pend_d      = 1'b0;
				end
			end
			S_PRIME: begin
				cmd.mem_re = 1'b1;
				src_d      = up_q ? src_q + AW'(1) : src_q - AW'(1);
				state_d    = S_MOVE;
			end
			S_MOVE: begin
				cmd.mem_we  = 1'b1;
				cmd.wsel_rd = 1'b1;
				dst_d       = up_q ? dst_q + AW'(1) : dst_q - AW'(1);
				left_d      = left_q - CW'(1);
				if (left_q != CW'(1)) begin
					cmd.mem_re = 1'b1;
					src_d      = up_q ? src_q + AW'(1) : src_q - AW'(1);
				end else begin
					state_d = ins_q ? S_PUT : S_RESP;
				end
			end
			S_PUT: begin
				cmd.mem_we = 1'b1;
				state_d    = S_RESP;
			end
			S_RESP: begin
				if (out_free) begin
					cmd.out_load   = 1'b1;
					cmd.out_status = st_q;
					cmd.out_last   = 1'b1;
					state_d        = S_IDLE;
				end
			end
			S_DISP: begin
				// read ahead one word while the response slot drains
				cmd.mem_re      = (left_q != '0) && (!pend_q || out_free);
				cmd.out_load    = pend_q && out_free;
				cmd.out_status  = ST_OK;
				cmd.out_elem_rd = 1'b1;
				cmd.out_last    = (olft_q == CW'(1));
				pend_d          = cmd.mem_re || (pend_q && !cmd.out_load);
				if (cmd.mem_re) begin
					src_d  = src_q + AW'(1);
					left_d = left_q - CW'(1);
				end
				if (cmd.out_load) begin
					olft_d = olft_q - CW'(1);
					if (olft_q == CW'(1)) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			src_q   <= '0;
			dst_q   <= '0;
			left_q  <= '0;
			olft_q  <= '0;
			up_q    <= 1'b0;
			ins_q   <= 1'b0;
			pend_q  <= 1'b0;
			st_q    <= ST_OK;
		end else begin
			state_q <= state_d;
			src_q   <= src_d;
			dst_q   <= dst_d;
			left_q  <= left_d;
			olft_q  <= olft_d;
			up_q    <= up_d;
			ins_q   <= ins_d;
			pend_q  <= pend_d;
			st_q    <= st_d;
		end
	end

	a_no_rw_collide: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mem_we && cmd.mem_re |-> waddr != raddr)
		else $error("memory read and write hit the same entry");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> out_free)
		else $error("response register overwritten before taken");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt <= CW'(CAPACITY))
		else $error("element count above capacity");

	a_disp_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DISP) && cmd.out_load |-> pend_q)
		else $error("display word loaded without a pending read");

endmodule
`default_nettype wire

/* tb/tb_positional_list_insert_delete_unit.sv */
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// tb_positional_list_insert_delete_unit
// Drives list commands through the command channel and checks every response
// word against its typed table row or a behavioral copy of the list. A short
// directed table covers the empty and bad-position cases first. Random grow and
// shrink phases follow, with sender bursts, receiver stalls, one long receiver
// hold and one full drain pause.
// -----------------------------------------------------------------------------
module tb_positional_list_insert_delete_unit;
	import pli_pkg::*;

	localparam int                CAP         = CAPACITY_DEF;
	localparam logic [MODE_W-1:0] MODE_NONE   = 3'd7;
	localparam int                RAND_ITEMS  = 460;
	localparam int                LONG_HOLD   = 300;
	localparam int                IDLE_LIMIT  = 5000;
	localparam int                TAIL_CYCLES = 40;
	localparam int                NUM_ROWS    = 24;

	typedef struct packed {
		logic [MODE_W-1:0]         mode;
		logic signed [VALUE_W-1:0] value;
		logic [POS_W-1:0]          position;
		logic                      typed;
		status_t                   status;
		logic [COUNT_W-1:0]        count;
	} cmd_row_t;

	typedef struct packed {
		status_t                   status;
		logic signed [VALUE_W-1:0] element;
		logic                      is_last;
		logic [COUNT_W-1:0]        count;
	} list_word_t;

	logic clk;
	logic arst_n;

	pli_cmd_if cmd_ch ();
	pli_rsp_if rsp_ch ();

	positional_list_insert_delete_unit #(
		.CAPACITY(CAP)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd_ch(cmd_ch),
		.rsp_ch(rsp_ch)
	);

	// list copy and outstanding response words
	logic signed [VALUE_W-1:0] list_store [CAP];
	int                        list_len;
	list_word_t                due_words [$];
	list_word_t                step_words [$];

	int fails;
	int idle_cycles;
	bit hold_rsp_req;
	int burst_left;

	// typed rows carry the single response word they must produce
	cmd_row_t dir_rows [NUM_ROWS] = '{
		'{MODE_DISPLAY,   32'sd0,            8'd0,   1'b1, ST_EMPTY,  5'd0},
		'{MODE_DEL_FRONT, 32'sd0,            8'd0,   1'b1, ST_EMPTY,  5'd0},
		'{MODE_DEL_BACK,  32'sd0,            8'd0,   1'b1, ST_EMPTY,  5'd0},
		'{MODE_DEL_POS,   32'sd0,            8'd1,   1'b1, ST_EMPTY,  5'd0},
		'{MODE_DEL_POS,   32'sd0,            8'd255, 1'b1, ST_EMPTY,  5'd0},
		'{MODE_INS_POS,   32'sd5,            8'd0,   1'b1, ST_BADPOS, 5'd0},
		'{MODE_INS_POS,   32'sd5,            8'd2,   1'b1, ST_BADPOS, 5'd0},
		'{MODE_INS_POS,   32'sh7FFF_FFFF,    8'd1,   1'b1, ST_OK,     5'd1},
		'{MODE_INS_FRONT, 32'sh8000_0000,    8'd0,   1'b1, ST_OK,     5'd2},
		'{MODE_INS_BACK,  -32'sd1,           8'd0,   1'b1, ST_OK,     5'd3},
		'{MODE_INS_POS,   32'sd0,            8'd4,   1'b1, ST_OK,     5'd4},
		'{MODE_INS_POS,   32'sh55AA_33CC,    8'd2,   1'b0, ST_OK,     5'd0},
		'{MODE_INS_POS,   32'sd9,            8'd255, 1'b1, ST_BADPOS, 5'd5},
		'{MODE_NONE,      -32'sd1,           8'd255, 1'b0, ST_OK,     5'd0},
		'{MODE_DISPLAY,   32'sd0,            8'd0,   1'b0, ST_OK,     5'd0},
		'{MODE_DEL_POS,   32'sd0,            8'd0,   1'b1, ST_BADPOS, 5'd5},
		'{MODE_DEL_POS,   32'sd0,            8'd6,   1'b1, ST_BADPOS, 5'd5},
		'{MODE_DEL_POS,   32'sd0,            8'd3,   1'b1, ST_OK,     5'd4},
		'{MODE_DEL_FRONT, 32'sd0,            8'd0,   1'b1, ST_OK,     5'd3},
		'{MODE_DEL_BACK,  32'sd0,            8'd0,   1'b1, ST_OK,     5'd2},
		'{MODE_DISPLAY,   32'sd0,            8'd0,   1'b0, ST_OK,     5'd0},
		'{MODE_DEL_POS,   32'sd0,            8'd2,   1'b1, ST_OK,     5'd1},
		'{MODE_DEL_POS,   32'sd0,            8'd1,   1'b1, ST_OK,     5'd0},
		'{MODE_DISPLAY,   32'sd0,            8'd0,   1'b1, ST_EMPTY,  5'd0}
	};

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic void list_insert(int idx, logic signed [VALUE_W-1:0] v);
		for (int i = list_len; i > idx; i--)
			list_store[i] = list_store[i-1];
		list_store[idx] = v;
		list_len++;
	endfunction

	function automatic void list_remove(int idx);
		for (int i = idx; i + 1 < list_len; i++)
			list_store[i] = list_store[i+1];
		list_len--;
	endfunction

	// apply one command to the list copy; response words land in step_words
	function automatic void list_update(logic [MODE_W-1:0] m, logic signed [VALUE_W-1:0] v,
	                                    logic [POS_W-1:0] p);
		status_t st;
		st = ST_OK;
		step_words.delete();
		case (m)
			MODE_INS_FRONT, MODE_INS_BACK, MODE_INS_POS: begin
				if (list_len >= CAP)
					st = ST_FULL;
				else if (m == MODE_INS_FRONT)
					list_insert(0, v);
				else if (m == MODE_INS_BACK)
					list_insert(list_len, v);
				else if (p >= 1 && p <= list_len + 1)
					list_insert(p - 1, v);
				else
					st = ST_BADPOS;
			end
			MODE_DEL_FRONT, MODE_DEL_BACK, MODE_DEL_POS: begin
				if (list_len == 0)
					st = ST_EMPTY;
				else if (m == MODE_DEL_FRONT)
					list_remove(0);
				else if (m == MODE_DEL_BACK)
					list_remove(list_len - 1);
				else if (p >= 1 && p <= list_len)
					list_remove(p - 1);
				else
					st = ST_BADPOS;
			end
			MODE_DISPLAY: begin
				if (list_len == 0)
					step_words.push_back('{ST_EMPTY, '0, 1'b1, '0});
				for (int i = 0; i < list_len; i++)
					step_words.push_back('{ST_OK, list_store[i], (i + 1 == list_len),
					                       COUNT_W'(list_len)});
				return;
			end
			default: return;
		endcase
		step_words.push_back('{st, '0, 1'b1, COUNT_W'(list_len)});
	endfunction

	function automatic logic signed [VALUE_W-1:0] pick_value();
		int r;
		r = $urandom_range(99);
		if (r < 4)
			return 32'sh7FFF_FFFF;
		else if (r < 8)
			return 32'sh8000_0000;
		else if (r < 10)
			return '0;
		else if (r < 12)
			return -32'sd1;
		return $signed($urandom);
	endfunction

	// top is the highest valid position for the command
	function automatic logic [POS_W-1:0] pick_position(int top);
		int r;
		r = $urandom_range(99);
		if (r < 78 && top >= 1)
			return POS_W'($urandom_range(top, 1));
		else if (r < 86)
			return '0;
		else if (r < 93 && top < 255)
			return POS_W'(top + 1);
		return POS_W'($urandom_range(255, 0));
	endfunction

	function automatic cmd_row_t random_cmd(bit grow);
		cmd_row_t c;
		int       r;
		c = '0;
		r = $urandom_range(99);
		if (r < (grow ? 60 : 25)) begin
			c.mode     = MODE_W'($urandom_range(2, 0));
			c.position = pick_position(list_len + 1);
		end else if (r < 85) begin
			c.mode     = MODE_DEL_FRONT + MODE_W'($urandom_range(2, 0));
			c.position = pick_position(list_len);
		end else if (r < 97) begin
			c.mode     = MODE_DISPLAY;
			c.position = POS_W'($urandom_range(255, 0));
		end else begin
			c.mode     = MODE_NONE;
			c.position = POS_W'($urandom_range(255, 0));
		end
		c.value = pick_value();
		return c;
	endfunction

	// offer one word, hold it until taken, then step to the next falling edge
	task automatic push_cmd(cmd_row_t c);
		cmd_ch.valid    <= 1'b1;
		cmd_ch.mode     <= c.mode;
		cmd_ch.value    <= c.value;
		cmd_ch.position <= c.position;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
		list_update(c.mode, c.value, c.position);
		if (c.typed)
			due_words.push_back('{c.status, '0, 1'b1, c.count});
		else
			foreach (step_words[i])
				due_words.push_back(step_words[i]);
		@(negedge clk);
	endtask

	// end of a burst: drop valid for a random gap
	task automatic idle_between();
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			burst_left   = ($urandom_range(7) == 0) ? $urandom_range(40, 16) :
			               $urandom_range(12, 1);
			cmd_ch.valid <= 1'b0;
			repeat ($urandom_range(8, 1))
				@(negedge clk);
		end
	endtask

	task automatic drain();
		while (due_words.size() != 0)
			@(negedge clk);
	endtask

	// response receiver: a phase counter picks a new random stall pattern; a hold request holds ready low
	initial begin
		int kind;
		int phase;
		rsp_ch.ready = 1'b0;
		kind         = 0;
		phase        = 0;
		forever begin
			@(negedge clk);
			if (hold_rsp_req) begin
				rsp_ch.ready <= 1'b0;
				repeat (LONG_HOLD)
					@(negedge clk);
				hold_rsp_req = 1'b0;
			end else begin
				phase++;
				if (phase % 128 == 0)
					kind = $urandom_range(3);
				case (kind)
					0: rsp_ch.ready <= 1'b1;
					1: rsp_ch.ready <= ($urandom_range(99) < 65);
					2: rsp_ch.ready <= (phase % 4 != 3);
					default: rsp_ch.ready <= ($urandom_range(99) < 20);
				endcase
			end
		end
	end

	// response checker
	always @(posedge clk) begin
		list_word_t want;
		if (rsp_ch.valid && rsp_ch.ready) begin
			if (due_words.size() == 0) begin
				fails++;
				$display("%0t: unexpected response word: status %0d element %0d last %0d count %0d",
				         $time, rsp_ch.status, rsp_ch.element, rsp_ch.is_last, rsp_ch.count);
			end else begin
				want = due_words.pop_front();
				if (rsp_ch.status !== want.status) begin
					fails++;
					$display("%0t: status mismatch: expected %0d, got %0d",
					         $time, want.status, rsp_ch.status);
				end
				if (rsp_ch.element !== want.element) begin
					fails++;
					$display("%0t: element mismatch: expected %0d, got %0d",
					         $time, want.element, rsp_ch.element);
				end
				if (rsp_ch.is_last !== want.is_last) begin
					fails++;
					$display("%0t: is_last mismatch: expected %0d, got %0d",
					         $time, want.is_last, rsp_ch.is_last);
				end
				if (rsp_ch.count !== want.count) begin
					fails++;
					$display("%0t: count mismatch: expected %0d, got %0d",
					         $time, want.count, rsp_ch.count);
				end
			end
		end
	end

	// watchdog: no word moved on either channel for too long
	always @(posedge clk) begin
		if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		int       sent;
		bit       grow;
		int       phase_left;
		cmd_row_t c;
		fails           = 0;
		idle_cycles     = 0;
		hold_rsp_req    = 1'b0;
		burst_left      = 4;
		list_len        = 0;
		arst_n          = 1'b0;
		cmd_ch.valid    = 1'b0;
		cmd_ch.mode     = '0;
		cmd_ch.value    = '0;
		cmd_ch.position = '0;
		repeat (7)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < NUM_ROWS; i++) begin
			push_cmd(dir_rows[i]);
			idle_between();
		end
		cmd_ch.valid <= 1'b0;
		drain();

		sent       = 0;
		grow       = 1'b1;
		phase_left = 60;
		while (sent < RAND_ITEMS) begin
			if (phase_left == 0) begin
				grow       = !grow;
				phase_left = $urandom_range(70, 30);
			end
			phase_left--;
			c = random_cmd(grow);
			push_cmd(c);
			if (c.mode != MODE_NONE)
				sent++;
			// keep offering while the receiver holds off
			if (sent == 150 && c.mode != MODE_NONE)
				hold_rsp_req = 1'b1;
			if (sent == 300 && c.mode != MODE_NONE) begin
				cmd_ch.valid <= 1'b0;
				drain();
			end else begin
				idle_between();
			end
		end
		cmd_ch.valid <= 1'b0;
		drain();
		repeat (TAIL_CYCLES)
			@(posedge clk);
		if (fails == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

/* filelist.f */
rtl/core/pli_pkg.sv
rtl/core/pli_if.sv
rtl/core/pli_dp.sv
rtl/core/pli_ctrl.sv
rtl/core/positional_list_insert_delete_unit.sv
tb/tb_positional_list_insert_delete_unit.sv
